### rtl/gridh_pkg.sv
// ----------------------------------------------------------------------------
// gridh_pkg
// Shared types, widths and codes of the 3d occupancy histogram.
// ----------------------------------------------------------------------------
package gridh_pkg;

  localparam int unsigned GRID_DIM   = 32;
  localparam int unsigned CELL_WIDTH = 40;

  localparam int unsigned AXIS_W    = 5;
  localparam int unsigned ADDR_W    = 3 * AXIS_W;
  localparam int unsigned DEPTH     = 1 << ADDR_W;
  localparam int unsigned POS_W     = 24;
  localparam int unsigned STEP_W    = 20;
  localparam int unsigned CNT_W     = 18;
  localparam int unsigned LIM_W     = 6;
  localparam int unsigned WEIGHT_W  = 16;
  localparam int unsigned VAL_W     = 40;
  localparam int unsigned TOTAL_W   = 48;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_LOW_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_Z  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_Z = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_COUNTS = 3'd6;

  localparam logic [STEP_W-1:0] STEP_RESET   = 20'd82;
  localparam logic [CNT_W-1:0]  COUNTS_RESET = 18'd133152;

  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_RMW,
    ST_MISS
  } state_e;

  typedef struct packed {
    logic              ok;
    logic [AXIS_W-1:0] idx;
  } axis_res_t;

  // smallest of packed count, GRID_DIM and the five-bit index reach
  function automatic logic [LIM_W-1:0] axis_limit(input logic [LIM_W-1:0] n);
    logic [LIM_W-1:0] lim;
    begin
      lim = n;
      if ({1'b0, lim} > (LIM_W+1)'(GRID_DIM)) lim = LIM_W'(GRID_DIM);
      if (lim > LIM_W'(1 << AXIS_W)) lim = LIM_W'(1 << AXIS_W);
      return lim;
    end
  endfunction

endpackage

### rtl/gridh_div.sv
// ----------------------------------------------------------------------------
// gridh_div
// Per-axis cell index: restoring division of the offset by the cell size,
// one quotient bit per cycle, with range check.
// ----------------------------------------------------------------------------
module gridh_div (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic signed [gridh_pkg::POS_W-1:0]   pos_i,
  input  logic signed [gridh_pkg::POS_W-1:0]   low_i,
  input  logic        [gridh_pkg::STEP_W-1:0]  step_i,
  input  logic        [gridh_pkg::LIM_W-1:0]   limit_i,
  output logic                                 done_o,
  output gridh_pkg::axis_res_t                 res_o
);

  localparam int unsigned TW = gridh_pkg::POS_W + 2;

  logic                               busy_q, busy_d;
  logic                               done_q, done_d;
  logic                               ok_q, ok_d;
  logic [2:0]                         cnt_q, cnt_d;
  logic [gridh_pkg::POS_W-1:0]        rem_q, rem_d;
  logic [gridh_pkg::STEP_W-1:0]       step_q, step_d;
  logic [gridh_pkg::AXIS_W-1:0]       quo_q, quo_d;
  logic [gridh_pkg::LIM_W-1:0]        lim_q, lim_d;
  logic signed [gridh_pkg::POS_W:0]   diff;
  logic [TW-1:0]                      trial;
  logic                               ge;

  assign diff  = (gridh_pkg::POS_W+1)'(pos_i) - (gridh_pkg::POS_W+1)'(low_i);
  assign trial = TW'(step_q) << cnt_q;
  assign ge    = TW'(rem_q) >= trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    ok_d   = ok_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    step_d = step_q;
    quo_d  = quo_q;
    lim_d  = lim_q;
    if (start_i) begin
      busy_d = 1'b1;
      ok_d   = !diff[gridh_pkg::POS_W] && (step_i != '0);
      cnt_d  = 3'(gridh_pkg::AXIS_W);
      rem_d  = diff[gridh_pkg::POS_W-1:0];
      step_d = step_i;
      quo_d  = '0;
      lim_d  = limit_i;
    end else if (busy_q) begin
      if (cnt_q == 3'(gridh_pkg::AXIS_W)) begin
        if (ge) ok_d = 1'b0;
      end else if (ge) begin
        rem_d        = rem_q - trial[gridh_pkg::POS_W-1:0];
        quo_d[cnt_q] = 1'b1;
      end
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ok_q   <= ok_d;
    rem_q  <= rem_d;
    step_q <= step_d;
    quo_q  <= quo_d;
    lim_q  <= lim_d;
  end

  assign done_o    = done_q;
  assign res_o.ok  = ok_q && ({1'b0, quo_q} < lim_q);
  assign res_o.idx = quo_q;

endmodule

### rtl/gridh_ram.sv
// ----------------------------------------------------------------------------
// gridh_ram
// Cell store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module gridh_ram (
  input  logic                              clk_i,
  input  logic                              we_i,
  input  logic [gridh_pkg::ADDR_W-1:0]      waddr_i,
  input  logic [gridh_pkg::CELL_WIDTH-1:0]  wdata_i,
  input  logic                              re_i,
  input  logic [gridh_pkg::ADDR_W-1:0]      raddr_i,
  output logic [gridh_pkg::CELL_WIDTH-1:0]  rdata_o
);

  logic [gridh_pkg::CELL_WIDTH-1:0] mem_q [gridh_pkg::DEPTH];
  logic [gridh_pkg::CELL_WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
  end

  always_ff @(posedge clk_i) begin
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/grid_occupancy_histogram_3d.sv
// ----------------------------------------------------------------------------
// grid_occupancy_histogram_3d
// 3d occupancy histogram: bins weighted points into a cell store with
// saturating accumulators and a running total; read words return one cell.
// ----------------------------------------------------------------------------
// order: add word ST_DIV then ST_RMW or ST_MISS; read word ST_READ
// throughput: one word in flight; an add word is bound by the six-step
//   restoring divider per axis
// reset: a clearing sweep writes zero to all 32768 cells, one per cycle,
//   before in_ready_o rises; config writes are taken throughout
module grid_occupancy_histogram_3d (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  logic [gridh_pkg::CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [gridh_pkg::CFG_DAT_W-1:0]          cfg_data_i,
  input  logic                                     in_valid_i,
  output logic                                     in_ready_o,
  input  logic                                     cmd_i,
  input  logic signed [gridh_pkg::POS_W-1:0]       pos_x_i,
  input  logic signed [gridh_pkg::POS_W-1:0]       pos_y_i,
  input  logic signed [gridh_pkg::POS_W-1:0]       pos_z_i,
  input  logic [gridh_pkg::WEIGHT_W-1:0]           weight_i,
  input  logic [gridh_pkg::ADDR_W-1:0]             read_addr_i,
  output logic                                     out_valid_o,
  input  logic                                     out_ready_i,
  output logic                                     hit_o,
  output logic [gridh_pkg::ADDR_W-1:0]             cell_addr_o,
  output logic [gridh_pkg::VAL_W-1:0]              cell_value_o,
  output logic [gridh_pkg::TOTAL_W-1:0]            total_weight_o
);

  localparam int unsigned CW = gridh_pkg::CELL_WIDTH;
  localparam int unsigned TW = gridh_pkg::TOTAL_W;

  gridh_pkg::state_e state_q, state_d;

  logic signed [gridh_pkg::POS_W-1:0] low_x_q, low_y_q, low_z_q;
  logic [gridh_pkg::STEP_W-1:0]       step_x_q, step_y_q, step_z_q;
  logic [gridh_pkg::CNT_W-1:0]        counts_q;

  logic [gridh_pkg::ADDR_W-1:0]   clr_q, clr_d;
  logic [gridh_pkg::ADDR_W-1:0]   addr_q, addr_d;
  logic [gridh_pkg::WEIGHT_W-1:0] weight_q, weight_d;
  logic [TW-1:0]                  total_q, total_d;

  logic                           out_valid_q, out_valid_d;
  logic                           hit_q, hit_d;
  logic [gridh_pkg::ADDR_W-1:0]   oaddr_q, oaddr_d;
  logic [gridh_pkg::VAL_W-1:0]    oval_q, oval_d;
  logic [TW-1:0]                  otot_q, otot_d;

  logic                           div_start;
  logic                           done_x, done_y, done_z;
  gridh_pkg::axis_res_t           res_x, res_y, res_z;

  logic                           mem_we, mem_re;
  logic [gridh_pkg::ADDR_W-1:0]   mem_waddr, mem_raddr;
  logic [CW-1:0]                  mem_wdata, mem_rdata;

  logic                           in_acc, out_free;
  logic [CW:0]                    cell_sum;
  logic [CW-1:0]                  cell_new;
  logic [TW:0]                    tot_sum;
  logic [TW-1:0]                  tot_new;

  // config registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_x_q  <= '0;
      low_y_q  <= '0;
      low_z_q  <= '0;
      step_x_q <= gridh_pkg::STEP_RESET;
      step_y_q <= gridh_pkg::STEP_RESET;
      step_z_q <= gridh_pkg::STEP_RESET;
      counts_q <= gridh_pkg::COUNTS_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        gridh_pkg::REG_LOW_X:  low_x_q  <= cfg_data_i[gridh_pkg::POS_W-1:0];
        gridh_pkg::REG_LOW_Y:  low_y_q  <= cfg_data_i[gridh_pkg::POS_W-1:0];
        gridh_pkg::REG_LOW_Z:  low_z_q  <= cfg_data_i[gridh_pkg::POS_W-1:0];
        gridh_pkg::REG_STEP_X: step_x_q <= cfg_data_i[gridh_pkg::STEP_W-1:0];
        gridh_pkg::REG_STEP_Y: step_y_q <= cfg_data_i[gridh_pkg::STEP_W-1:0];
        gridh_pkg::REG_STEP_Z: step_z_q <= cfg_data_i[gridh_pkg::STEP_W-1:0];
        gridh_pkg::REG_COUNTS: counts_q <= cfg_data_i[gridh_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  gridh_div u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .pos_i   (pos_x_i),
    .low_i   (low_x_q),
    .step_i  (step_x_q),
    .limit_i (gridh_pkg::axis_limit(counts_q[5:0])),
    .done_o  (done_x),
    .res_o   (res_x)
  );

  gridh_div u_div_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .pos_i   (pos_y_i),
    .low_i   (low_y_q),
    .step_i  (step_y_q),
    .limit_i (gridh_pkg::axis_limit(counts_q[11:6])),
    .done_o  (done_y),
    .res_o   (res_y)
  );

  gridh_div u_div_z (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .pos_i   (pos_z_i),
    .low_i   (low_z_q),
    .step_i  (step_z_q),
    .limit_i (gridh_pkg::axis_limit(counts_q[17:12])),
    .done_o  (done_z),
    .res_o   (res_z)
  );

  gridh_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // saturating accumulate
  assign cell_sum = {1'b0, mem_rdata} + (CW+1)'(weight_q);
  assign cell_new = cell_sum[CW] ? '1 : cell_sum[CW-1:0];
  assign tot_sum  = {1'b0, total_q} + (TW+1)'(weight_q);
  assign tot_new  = tot_sum[TW] ? '1 : tot_sum[TW-1:0];

  assign in_ready_o = (state_q == gridh_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    addr_d      = addr_q;
    weight_d    = weight_q;
    total_d     = total_q;
    out_valid_d = out_valid_q && !out_ready_i;
    hit_d       = hit_q;
    oaddr_d     = oaddr_q;
    oval_d      = oval_q;
    otot_d      = otot_q;
    div_start   = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = addr_q;
    mem_wdata   = cell_new;
    mem_re      = 1'b0;
    mem_raddr   = read_addr_i;
    case (state_q)
      gridh_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + 1'b1;
        if (&clr_q) state_d = gridh_pkg::ST_IDLE;
      end
      gridh_pkg::ST_IDLE: begin
        if (in_acc) begin
          weight_d = weight_i;
          addr_d   = read_addr_i;
          if (cmd_i == gridh_pkg::CMD_READ) begin
            mem_re  = 1'b1;
            state_d = gridh_pkg::ST_READ;
          end else begin
            div_start = 1'b1;
            state_d   = gridh_pkg::ST_DIV;
          end
        end
      end
      gridh_pkg::ST_DIV: begin
        if (done_x) begin
          if (res_x.ok && res_y.ok && res_z.ok) begin
            addr_d    = {res_x.idx, res_y.idx, res_z.idx};
            mem_re    = 1'b1;
            mem_raddr = addr_d;
            state_d   = gridh_pkg::ST_RMW;
          end else begin
            state_d = gridh_pkg::ST_MISS;
          end
        end
      end
      gridh_pkg::ST_READ: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          hit_d       = 1'b1;
          oaddr_d     = addr_q;
          oval_d      = gridh_pkg::VAL_W'(mem_rdata);
          otot_d      = total_q;
          state_d     = gridh_pkg::ST_IDLE;
        end
      end
      gridh_pkg::ST_RMW: begin
        if (out_free) begin
          mem_we      = 1'b1;
          total_d     = tot_new;
          out_valid_d = 1'b1;
          hit_d       = 1'b1;
          oaddr_d     = addr_q;
          oval_d      = gridh_pkg::VAL_W'(cell_new);
          otot_d      = tot_new;
          state_d     = gridh_pkg::ST_IDLE;
        end
      end
      gridh_pkg::ST_MISS: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          hit_d       = 1'b0;
          oaddr_d     = '0;
          oval_d      = '0;
          otot_d      = total_q;
          state_d     = gridh_pkg::ST_IDLE;
        end
      end
      default: state_d = gridh_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gridh_pkg::ST_CLEAR;
      clr_q       <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q   <= addr_d;
    weight_q <= weight_d;
    hit_q    <= hit_d;
    oaddr_q  <= oaddr_d;
    oval_q   <= oval_d;
    otot_q   <= otot_d;
  end

  assign out_valid_o    = out_valid_q;
  assign hit_o          = hit_q;
  assign cell_addr_o    = oaddr_q;
  assign cell_value_o   = oval_q;
  assign total_weight_o = otot_q;

  // running total only grows
  a_total_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q >= $past(total_q))
    else $error("running total decreased");

  // store written only by the sweep or an accumulate
  a_we_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == gridh_pkg::ST_CLEAR || state_q == gridh_pkg::ST_RMW))
    else $error("unexpected store write");

  // a miss carries no cell
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !hit_o) |-> (cell_value_o == '0 && cell_addr_o == '0))
    else $error("miss word carries a cell");

  // all axis lanes finish together
  a_lanes_sync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_x |-> (done_y && done_z))
    else $error("divider lanes out of step");

endmodule
